// File: rtl/long_integer_alu_32_unit_macros.svh
// ----------------------------------------------------------------------------
// long_integer_alu_32_unit macros
// assertion helpers for the alu top-level rtl
// ----------------------------------------------------------------------------
`ifndef LONG_INTEGER_ALU_32_UNIT_MACROS_SVH
`define LONG_INTEGER_ALU_32_UNIT_MACROS_SVH
`ifndef SYNTH
`define LIA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LIA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define LIA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/lia32_pkg.sv
// ----------------------------------------------------------------------------
// lia32_pkg
// shared types and command codes for the 32-bit alu
// ----------------------------------------------------------------------------
package lia32_pkg;
  localparam int unsigned DataW  = 32;
  localparam int unsigned HalfW  = 16;
  // front stage, one divider step per quotient bit, sign fix, output
  localparam int unsigned StagesDefault = DataW + 3;

  typedef enum logic [4:0] {
    CMD_SET = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
    CMD_DIV = 5'd4, CMD_AND = 5'd5, CMD_OR = 5'd6, CMD_XOR = 5'd7,
    CMD_EQ = 5'd8, CMD_LT = 5'd9, CMD_LE = 5'd10, CMD_GT = 5'd11,
    CMD_GE = 5'd12, CMD_NOT = 5'd13, CMD_BSET = 5'd14, CMD_BCLR = 5'd15,
    CMD_BTGL = 5'd16, CMD_BTST = 5'd17, CMD_SHL = 5'd18, CMD_SHR = 5'd19,
    CMD_SWAP = 5'd20, CMD_NEG = 5'd21, CMD_ABS = 5'd22
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BADCMD = 2'd2
  } status_t;

  // result of the front stage, carried beside the divider
  typedef struct packed {
    logic [DataW-1:0] cur;
    logic [DataW-1:0] res;
    logic             flag;
    logic [1:0]       status;
    logic             is_div;
    logic             neg_q;
  } front_t;
endpackage

// File: rtl/long_integer_alu_32_unit.sv
// ----------------------------------------------------------------------------
// long_integer_alu_32_unit
// 32-bit signed alu for a script interpreter, fully pipelined
// ----------------------------------------------------------------------------
// pipeline: an input transfer passes the front stage, 32 divider steps,
//   sign fix and output, one per pipeline stage
// throughput: one transfer per cycle; the whole pipe advances when the output
//   register is free or being taken, so a stall freezes every stage
// reset: rst clears the valid bits only; data registers are not reset
module long_integer_alu_32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[4:0], current_value[36:5], arg_low[52:37], arg_high[68:53]
  input  logic [71:0] s_tdata,
  // arg_is_wide
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // new_value[31:0], value_changed[32]
  output logic [39:0] m_tdata,
  // flag[0], status[2:1]
  output logic [2:0]  m_tuser
);
  import lia32_pkg::*;
  `include "long_integer_alu_32_unit_macros.svh"

  // one register stage per valid bit
  localparam int unsigned Stages = StagesDefault;
  // one divider step per quotient bit, between front and sign fix
  localparam int unsigned DivSteps = DataW;

  logic adv;
  logic [Stages-1:0] vld;

  // front stage outputs
  front_t front;
  logic [DataW-1:0] mag_a, mag_b;

  // divider chain and side pipe of front results
  logic [DataW-1:0] rem_c [DivSteps+1];
  logic [DataW-1:0] quo_c [DivSteps+1];
  logic [DataW-1:0] dvs_c [DivSteps+1];
  front_t side [DivSteps+1];

  // sign fix and output registers
  front_t fix;
  logic [DataW-1:0] fix_q, out_val;
  logic out_flag, out_chg;
  logic [1:0] out_st;

  // whole pipe moves together; a bubble in the output register lets it move
  assign adv = m_tready || !vld[Stages-1];
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Stages-2:0], s_tvalid};
    end
  end

  lia32_front u_front (
    .clk(clk), .en(adv),
    .command(s_tdata[4:0]), .current_value(s_tdata[36:5]),
    .arg_low(s_tdata[52:37]), .arg_high(s_tdata[68:53]),
    .arg_is_wide(s_tuser),
    .front(front), .mag_a(mag_a), .mag_b(mag_b)
  );

  assign rem_c[0] = '0;
  assign quo_c[0] = mag_a;
  assign dvs_c[0] = mag_b;
  assign side[0]  = front;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    lia32_div_stage u_step (
      .clk(clk), .en(adv),
      .rem_in(rem_c[i]), .quo_in(quo_c[i]), .dvs_in(dvs_c[i]),
      .rem_out(rem_c[i+1]), .quo_out(quo_c[i+1]), .dvs_out(dvs_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        side[i+1] <= side[i];
      end
    end
  end

  // sign fix of the quotient
  always_ff @(posedge clk) begin
    if (adv) begin
      fix   <= side[DivSteps];
      fix_q <= side[DivSteps].neg_q ? '0 - quo_c[DivSteps] : quo_c[DivSteps];
    end
  end

  // output register, held while the sink stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      out_val  <= fix.is_div ? fix_q : fix.res;
      out_chg  <= (fix.is_div ? fix_q : fix.res) != fix.cur;
      out_flag <= fix.flag;
      out_st   <= fix.status;
    end
  end

  assign m_tvalid = vld[Stages-1];
  assign m_tdata  = {7'd0, out_chg, out_val};
  assign m_tuser  = {out_st, out_flag};

  `LIA_ASSERT_IMPL(a_stall_ready, clk, rst, m_tvalid && !m_tready, !s_tready)
  `LIA_ASSERT_NEXT(a_hold_out, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LIA_ASSERT_IMPL(a_err_nochg, clk, rst, m_tvalid && m_tuser[2:1] != ST_OK, !m_tdata[32])
  `LIA_ASSERT_IMPL(a_flag_ok, clk, rst, m_tvalid && m_tuser[0], m_tuser[2:1] == ST_OK)
endmodule

// File: rtl/lia32_front.sv
// ----------------------------------------------------------------------------
// lia32_front
// argument build, divide setup and all other operations, registered
// ----------------------------------------------------------------------------
module lia32_front (
  input  logic                      clk,
  input  logic                      en,
  input  logic [4:0]                command,
  input  logic [lia32_pkg::DataW-1:0] current_value,
  input  logic [15:0]               arg_low,
  input  logic [15:0]               arg_high,
  input  logic                      arg_is_wide,
  output lia32_pkg::front_t         front,
  output logic [lia32_pkg::DataW-1:0] mag_a,
  output logic [lia32_pkg::DataW-1:0] mag_b
);
  import lia32_pkg::*;

  logic [DataW-1:0] arg, bitm, prod;
  logic [4:0] n;
  logic lt_ca, lt_ac;
  front_t f_next;

  always_comb begin
    arg  = arg_is_wide ? {arg_high, arg_low} : {{HalfW{arg_low[15]}}, arg_low};
    n    = arg_low[4:0];
    bitm = {{(DataW-1){1'b0}}, 1'b1} << n;
    prod = current_value * arg;
    lt_ca = $signed(current_value) < $signed(arg);
    lt_ac = $signed(arg) < $signed(current_value);
    f_next = '0;
    f_next.cur = current_value;
    f_next.res = current_value;
    case (command)
      CMD_SET:  f_next.res = arg;
      CMD_ADD:  f_next.res = current_value + arg;
      CMD_SUB:  f_next.res = current_value - arg;
      CMD_MUL:  f_next.res = prod;
      CMD_DIV: begin
        if (arg == '0) f_next.status = ST_DIV0;
        else f_next.is_div = 1'b1;
        f_next.neg_q = current_value[DataW-1] ^ arg[DataW-1];
      end
      CMD_AND:  f_next.res = current_value & arg;
      CMD_OR:   f_next.res = current_value | arg;
      CMD_XOR:  f_next.res = current_value ^ arg;
      CMD_EQ:   f_next.flag = current_value == arg;
      CMD_LT:   f_next.flag = lt_ca;
      CMD_LE:   f_next.flag = !lt_ac;
      CMD_GT:   f_next.flag = lt_ac;
      CMD_GE:   f_next.flag = !lt_ca;
      CMD_NOT:  f_next.res = ~current_value;
      CMD_BSET: f_next.res = current_value | bitm;
      CMD_BCLR: f_next.res = current_value & ~bitm;
      CMD_BTGL: f_next.res = current_value ^ bitm;
      CMD_BTST: f_next.flag = (current_value & bitm) != '0;
      CMD_SHL:  f_next.res = current_value << n;
      CMD_SHR:  f_next.res = $unsigned($signed(current_value) >>> n);
      CMD_SWAP: f_next.res = {current_value[HalfW-1:0], current_value[DataW-1:HalfW]};
      CMD_NEG:  f_next.res = '0 - current_value;
      CMD_ABS:  f_next.res = current_value[DataW-1] ? '0 - current_value : current_value;
      default:  f_next.status = ST_BADCMD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= f_next;
      mag_a <= current_value[DataW-1] ? '0 - current_value : current_value;
      mag_b <= arg[DataW-1] ? '0 - arg : arg;
    end
  end
endmodule

// File: rtl/lia32_div_stage.sv
// ----------------------------------------------------------------------------
// lia32_div_stage
// one restoring step of the unsigned divider, registered
// ----------------------------------------------------------------------------
module lia32_div_stage (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lia32_pkg::DataW-1:0] rem_in,
  input  logic [lia32_pkg::DataW-1:0] quo_in,
  input  logic [lia32_pkg::DataW-1:0] dvs_in,
  output logic [lia32_pkg::DataW-1:0] rem_out,
  output logic [lia32_pkg::DataW-1:0] quo_out,
  output logic [lia32_pkg::DataW-1:0] dvs_out
);
  import lia32_pkg::*;

  logic [DataW:0] trial, diff;

  always_comb begin
    trial = {rem_in, quo_in[DataW-1]};
    diff  = trial - {1'b0, dvs_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      quo_out <= {quo_in[DataW-2:0], ~diff[DataW]};
      dvs_out <= dvs_in;
    end
  end
endmodule
